// File: design/tpp_pkg.sv
// Package: constants, field widths and pipeline payload types for the peak interpolator.
package tpp_pkg;
    localparam int SampleBitsDef   = 16;
    localparam int FractionBitsDef = 8;
    localparam int QueryBits       = 16;
    localparam int ValueWidth      = 40;
    localparam int SlopeWidth      = 34;
    localparam int CurvWidth       = 18;
    localparam int PeakWidth       = 25;

    typedef struct packed {
        logic signed [ValueWidth-1:0] value;
        logic signed [SlopeWidth-1:0] slope;
        logic signed [CurvWidth-1:0]  curv;
        logic                         flat;
    } t_poly_res;
endpackage

// File: design/tpp_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
module tpp_div
    import tpp_pkg::*;
#(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 18
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic signed [DEN_BITS-1:0] i_den,
    output logic                       o_valid,
    output logic signed [NUM_BITS-1:0] o_quo
);
    localparam int Steps = NUM_BITS;

    logic [NUM_BITS-1:0] r_q   [Steps+1];
    logic [DEN_BITS:0]   r_rem [Steps+1];
    logic [DEN_BITS-1:0] r_d   [Steps+1];
    logic                r_neg [Steps+1];
    logic                r_v   [Steps+1];

    // load magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_q[0]   <= i_num[NUM_BITS-1] ? NUM_BITS'(-i_num) : i_num;
            r_d[0]   <= i_den[DEN_BITS-1] ? DEN_BITS'(-i_den) : i_den;
            r_neg[0] <= i_num[NUM_BITS-1] ^ i_den[DEN_BITS-1];
            r_rem[0] <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar s = 0; s < Steps; s++) begin : g_step
        logic [DEN_BITS+1:0] w_tr;
        logic [DEN_BITS+1:0] w_sub;
        assign w_tr  = {r_rem[s], r_q[s][NUM_BITS-1]};
        assign w_sub = w_tr - {2'b00, r_d[s]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_en) begin
                r_d[s+1]   <= r_d[s];
                r_neg[s+1] <= r_neg[s];
                if (!w_sub[DEN_BITS+1]) begin
                    r_rem[s+1] <= w_sub[DEN_BITS:0];
                    r_q[s+1]   <= {r_q[s][NUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= w_tr[DEN_BITS:0];
                    r_q[s+1]   <= {r_q[s][NUM_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[Steps];
    assign o_quo   = r_neg[Steps] ? NUM_BITS'(-r_q[Steps]) : r_q[Steps];
endmodule

// File: design/tpp_poly.sv
// Polynomial pipeline: value, slope and curvature of the fitted parabola.
module tpp_poly
    import tpp_pkg::*;
#(
    parameter int SAMPLE_BITS   = SampleBitsDef,
    parameter int FRACTION_BITS = FractionBitsDef,
    parameter int DEPTH         = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_y0,
    input  logic signed [SAMPLE_BITS-1:0] i_y1,
    input  logic signed [SAMPLE_BITS-1:0] i_y2,
    input  logic signed [QueryBits-1:0]   i_x,
    output logic                          o_valid,
    output t_poly_res                     o_res
);
    localparam int W  = 64;
    localparam int DW = SAMPLE_BITS + 2;
    localparam int UW = QueryBits + 1;
    localparam int PW = DW + UW;
    localparam int QW = DW + 2*UW;

    logic signed [SAMPLE_BITS-1:0] r_y1, r2_y1, r3_y1;
    logic signed [DW-1:0]          r_d, r_c, r2_d, r2_c, r3_d, r3_c;
    logic signed [UW-1:0]          r_u, r2_u;
    logic signed [PW-1:0]          r2_du, r2_cu, r3_du, r3_cu;
    logic signed [QW-1:0]          r3_cuu;
    logic [2:0]          r_v;
    t_poly_res           r_dly [DEPTH];
    logic                r_dv  [DEPTH];
    logic signed [W-1:0] w_num, w_sn;

    // stage 1: differences; stage 2: first products; stage 3: second product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
        if (i_en) begin
            r_y1 <= i_y1;
            r_d  <= DW'(i_y2) - DW'(i_y0);
            r_c  <= DW'(i_y0) - (DW'(i_y1) <<< 1) + DW'(i_y2);
            r_u  <= UW'(i_x) - (UW'(1) <<< FRACTION_BITS);
            r2_y1 <= r_y1; r2_d <= r_d; r2_c <= r_c; r2_u <= r_u;
            r2_du <= r_d * r_u;
            r2_cu <= r_c * r_u;
            r3_y1 <= r2_y1; r3_d <= r2_d; r3_c <= r2_c; r3_cu <= r2_cu;
            r3_du  <= r2_du;
            r3_cuu <= r2_cu * r2_u;
        end
    end

    // combine and floor
    assign w_num = (W'(r3_y1) <<< (2*FRACTION_BITS+1)) + (W'(r3_du) <<< FRACTION_BITS)
                 + W'(r3_cuu);
    assign w_sn  = (W'(r3_d) <<< FRACTION_BITS) + (W'(r3_cu) <<< 1);

    // delay to line up with the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_dv[k] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_v[2];
            for (int k = 1; k < DEPTH; k++) r_dv[k] <= r_dv[k-1];
        end
        if (i_en) begin
            r_dly[0].value <= ValueWidth'(w_num >>> (FRACTION_BITS+1));
            r_dly[0].slope <= SlopeWidth'(w_sn >>> 1);
            r_dly[0].curv  <= CurvWidth'(r3_c);
            r_dly[0].flat  <= (r3_c == '0);
            for (int k = 1; k < DEPTH; k++) r_dly[k] <= r_dly[k-1];
        end
    end

    assign o_valid = r_dv[DEPTH-1];
    assign o_res   = r_dly[DEPTH-1];
endmodule

// File: design/three_point_parabolic_peak.sv
// Top level: three-point parabolic interpolator with output skid buffer.
// Usage: present y0, y1, y2 and a Q.F query offset on the s_axis channel;
// one result per item leaves on m_axis in input order.
// Throughput: one item per cycle while the output is not stalled; the
// pipeline is gated by a single enable. Each item passes through the
// bit-serial pipelined vertex divider (the load stage, then one quotient bit
// per stage) and then the output register.
// Value and slope use three stages (differences, products, second product)
// and then wait in a delay line beside the divider.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
// Stall: when m_axis_tready is low and the output register is full, the pipe
// freezes; s_axis_tready drops only then, so no transaction is lost or
// repeated. While the output holds a waiting result that is not taken, no
// fresh item is accepted.
module three_point_parabolic_peak
    import tpp_pkg::*;
#(
    parameter int SAMPLE_BITS   = SampleBitsDef,
    parameter int FRACTION_BITS = FractionBitsDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // left[SB-1:0], centre, right, query (16 bits), zero-filled to bytes
    input  logic [((3*SAMPLE_BITS+QueryBits+7)/8)*8-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // value[39:0], slope[73:40], curvature[91:74], peak[116:92], zero fill
    output logic [119:0]            m_axis_tdata,
    // no_peak
    output logic                    m_axis_tuser
);
    localparam int NumBits = SAMPLE_BITS + FRACTION_BITS + 2;
    localparam int DenBits = SAMPLE_BITS + 3;
    localparam int Depth   = NumBits + 1 - 3;

    logic signed [SAMPLE_BITS-1:0] w_y0, w_y1, w_y2;
    logic signed [QueryBits-1:0]   w_x;
    logic                          w_en, w_pv, w_dv;
    t_poly_res                     w_res;
    logic signed [NumBits-1:0]     w_num, w_quo;
    logic signed [DenBits-1:0]     w_den;
    logic                          r_ov;
    logic [119:0]                  r_od;
    logic                          r_ou;
    logic signed [PeakWidth-1:0]   w_peak;

    assign w_y0 = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_y1 = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_y2 = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign w_x  = s_axis_tdata[3*SAMPLE_BITS+QueryBits-1:3*SAMPLE_BITS];

    // advance when the output register is free or being drained
    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_num = (NumBits'(w_y0) - NumBits'(w_y2)) <<< FRACTION_BITS;
    assign w_den = (DenBits'(w_y0) - (DenBits'(w_y1) <<< 1) + DenBits'(w_y2)) <<< 1;

    tpp_poly #(.SAMPLE_BITS(SAMPLE_BITS), .FRACTION_BITS(FRACTION_BITS), .DEPTH(Depth)) u_poly (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(s_axis_tvalid),
        .i_y0(w_y0), .i_y1(w_y1), .i_y2(w_y2), .i_x(w_x),
        .o_valid(w_pv), .o_res(w_res)
    );

    tpp_div #(.NUM_BITS(NumBits), .DEN_BITS(DenBits)) u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(s_axis_tvalid),
        .i_num(w_num), .i_den(w_den), .o_valid(w_dv), .o_quo(w_quo)
    );

    assign w_peak = w_res.flat ? '0
                  : PeakWidth'(w_quo) + (PeakWidth'(1) <<< FRACTION_BITS);

    // hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_pv && w_dv;
        end
        if (w_en) begin
            r_od <= {3'b000, w_peak, w_res.curv, w_res.slope, w_res.value};
            r_ou <= w_res.flat;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_ou;
endmodule
